FILE: hdl/brb_pkg.sv
// Shared types and constants for the byte ring buffer with pattern search.
`timescale 1ns / 1ps
`default_nettype none
package brb_pkg;

    localparam logic [2:0] OP_WRITE    = 3'd0;
    localparam logic [2:0] OP_READ     = 3'd1;
    localparam logic [2:0] OP_DISCARD  = 3'd2;
    localparam logic [2:0] OP_FIND     = 3'd3;
    localparam logic [2:0] OP_READ_TIL = 3'd4;
    localparam logic [2:0] OP_SUB      = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SHORT    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    localparam logic [1:0] CFG_CAPACITY = 2'd0;
    localparam logic [1:0] CFG_PATTERN  = 2'd1;
    localparam logic [1:0] CFG_PAT_LEN  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMIT,
        S_SEARCH,
        S_RESULT
    } state_t;

endpackage
`default_nettype wire

FILE: hdl/brb_store.sv
// Byte store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module brb_store #(
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [7:0]               wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [7:0]               rdata
);
    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: hdl/byte_ring_buffer_with_pattern_search.sv
// Top level: ring buffer control, search sequencer and output register.
`timescale 1ns / 1ps
`default_nettype none
// Byte ring buffer with pattern search. A string streams in at one byte per
// cycle while results are taken as they come. Read, read until and sub range
// walk the single store read port, issuing the next address only as each
// registered byte is handed over. Find tries each start offset and compares
// the pattern byte by byte through the same port. Each result waits in one
// output register until taken; a new word is taken only when that register is
// free or being emptied. No clearing pass is needed after reset.
module byte_ring_buffer_with_pattern_search #(
    parameter int CAPACITY    = 64,
    parameter int MAX_PATTERN = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // operation[2:0], data_byte[10:3], byte_count[17:11], first_of_string[18],
    // peek_only[19], range_start[27:20], range_end[35:28], zero pad
    input  wire logic [39:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // out_byte[7:0], byte_valid[8], status[10:9], result_value[17:11],
    // fill_level[24:18], zero pad
    output logic [31:0]      m_tdata,
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    localparam int AW = $clog2(CAPACITY);
    localparam int PW = $clog2(MAX_PATTERN + 1);
    localparam logic [6:0] CAP7 = 7'(CAPACITY);
    localparam logic [3:0] MAXP4 = 4'(MAX_PATTERN);

    logic [2:0] op;
    logic [7:0] din;
    logic [6:0] cnt;
    logic       first, peek;
    logic signed [8:0] rs, re;
    assign op    = s_tdata[2:0];
    assign din   = s_tdata[10:3];
    assign cnt   = s_tdata[17:11];
    assign first = s_tdata[18];
    assign peek  = s_tdata[19];
    assign rs    = 9'(signed'(s_tdata[27:20]));
    assign re    = 9'(signed'(s_tdata[35:28]));

    brb_pkg::state_t state_reg, state_next;
    logic [6:0]  cap_reg, cap_next;
    logic [63:0] pat_reg, pat_next;
    logic [PW-1:0] plen_reg, plen_next;
    logic [AW-1:0] rp_reg, rp_next, wp_reg, wp_next;
    logic [6:0]  held_reg, held_next, left_reg, left_next;
    logic        rej_reg, rej_next;
    // walk control
    logic [6:0]  base_reg, base_next;   // start offset (search candidate or emit start)
    logic [6:0]  idx_reg, idx_next;     // bytes emitted / pattern index
    logic [6:0]  num_reg, num_next;     // bytes to emit / match end
    logic        rd_pend_reg, rd_pend_next;
    logic        consume_reg, consume_next;
    logic        til_reg, til_next;
    // output register
    logic        ov_reg, ov_next;
    logic [24:0] od_reg, od_next;
    logic        ol_reg, ol_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_rdata;
    logic [6:0]    roff;

    brb_store #(.DEPTH(CAPACITY)) u_store (
        .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(din),
        .raddr(mem_raddr), .rdata(mem_rdata)
    );

    // address = (p + off) mod cap, for p < cap and off <= cap
    function automatic logic [AW-1:0] wrap(input logic [AW-1:0] p, input logic [6:0] off,
                                           input logic [6:0] cap);
        logic [7:0] s;
        s = 8'(p) + 8'(off);
        if (s >= 8'(cap)) s = s - 8'(cap);
        return AW'(s);
    endfunction

    assign mem_raddr = wrap(rp_reg, roff, cap_reg);
    assign mem_waddr = wp_reg;

    logic out_free;
    assign out_free = !ov_reg || m_tready;

    logic [7:0] pbyte;
    assign pbyte = pat_reg[{idx_reg[2:0], 3'b000} +: 8];

    always_comb
    begin
        logic [6:0] tot;
        logic signed [8:0] s, e, h;
        state_next = state_reg;
        cap_next = cap_reg; pat_next = pat_reg; plen_next = plen_reg;
        rp_next = rp_reg; wp_next = wp_reg; held_next = held_reg;
        left_next = left_reg; rej_next = rej_reg;
        base_next = base_reg; idx_next = idx_reg; num_next = num_reg;
        rd_pend_next = 1'b0; consume_next = consume_reg; til_next = til_reg;
        ov_next = ov_reg && !m_tready; od_next = od_reg; ol_next = ol_reg;
        mem_we = 1'b0; roff = 7'(base_reg + idx_reg);
        s_tready = 1'b0;
        tot = 7'd0; h = 9'(held_reg); s = 9'sd0; e = 9'sd0;

        unique case (state_reg)
            brb_pkg::S_IDLE:
            begin
                s_tready = out_free;
                if (s_tvalid && out_free)
                begin
                    od_next = '0; ol_next = 1'b1; ov_next = 1'b1;
                    state_next = brb_pkg::S_IDLE;
                    unique case (op)
                        brb_pkg::OP_WRITE:
                        begin
                            od_next[10:9] = brb_pkg::ST_SHORT;
                            if (first)
                            begin
                                rej_next = 1'b0; left_next = 7'd0;
                                if (8'(cnt) + 8'(held_reg) > 8'(cap_reg))
                                begin
                                    left_next = (cnt != 0) ? cnt - 7'd1 : 7'd0;
                                    rej_next = cnt > 7'd1;
                                end
                                else if (cnt == 0)
                                    od_next[10:9] = brb_pkg::ST_OK;
                                else
                                begin
                                    mem_we = 1'b1;
                                    wp_next = wrap(wp_reg, 7'd1, cap_reg);
                                    held_next = held_reg + 7'd1;
                                    left_next = cnt - 7'd1;
                                    od_next[10:9] = brb_pkg::ST_OK;
                                    od_next[17:11] = 7'd1;
                                end
                            end
                            else if (rej_reg)
                            begin
                                if (left_reg != 0) left_next = left_reg - 7'd1;
                                if (left_reg <= 7'd1) rej_next = 1'b0;
                            end
                            else if (left_reg != 0 && held_reg < cap_reg)
                            begin
                                mem_we = 1'b1;
                                wp_next = wrap(wp_reg, 7'd1, cap_reg);
                                held_next = held_reg + 7'd1;
                                left_next = left_reg - 7'd1;
                                od_next[10:9] = brb_pkg::ST_OK;
                                od_next[17:11] = 7'd1;
                            end
                            od_next[24:18] = held_next;
                        end
                        brb_pkg::OP_READ, brb_pkg::OP_DISCARD:
                        begin
                            if (cnt > held_reg)
                                od_next[10:9] = brb_pkg::ST_SHORT;
                            else if (op == brb_pkg::OP_DISCARD || cnt == 0)
                            begin
                                held_next = held_reg - cnt;
                                rp_next = wrap(rp_reg, cnt, cap_reg);
                            end
                            else
                            begin
                                ov_next = ov_reg && !m_tready;
                                base_next = 7'd0; idx_next = 7'd0; num_next = cnt;
                                consume_next = !peek; roff = 7'd0;
                                rd_pend_next = 1'b1;
                                state_next = brb_pkg::S_EMIT;
                            end
                            od_next[24:18] = held_next;
                        end
                        brb_pkg::OP_FIND, brb_pkg::OP_READ_TIL:
                        begin
                            til_next = op == brb_pkg::OP_READ_TIL;
                            if (held_reg == 0 || 7'(plen_reg) > held_reg)
                            begin
                                od_next[10:9] = brb_pkg::ST_NOTFOUND;
                                od_next[24:18] = held_reg;
                            end
                            else
                            begin
                                ov_next = ov_reg && !m_tready;
                                base_next = 7'd0; idx_next = 7'd0; roff = 7'd0;
                                rd_pend_next = 1'b1;
                                state_next = brb_pkg::S_SEARCH;
                            end
                        end
                        brb_pkg::OP_SUB:
                        begin
                            s = rs; e = re;
                            if (s < 0) s = 9'sd1 + s + h;
                            if (s < 1) s = 9'sd1;
                            if (e < 0) e = 9'sd1 + e + h;
                            if (e > h) e = h;
                            od_next[24:18] = held_reg;
                            if (s <= e)
                            begin
                                ov_next = ov_reg && !m_tready;
                                base_next = 7'(s - 9'sd1); idx_next = 7'd0;
                                num_next = 7'(e - s + 9'sd1);
                                consume_next = 1'b0; roff = 7'(s - 9'sd1);
                                rd_pend_next = 1'b1;
                                state_next = brb_pkg::S_EMIT;
                            end
                        end
                        default:
                        begin
                            od_next[10:9] = brb_pkg::ST_SHORT;
                            od_next[24:18] = held_reg;
                        end
                    endcase
                end
            end
            brb_pkg::S_EMIT:
            begin
                // once no read is pending, rdata holds byte idx; hand it over when the output is free
                tot = idx_reg + 7'd1;
                if (out_free && rd_pend_reg == 1'b0)
                begin
                    ov_next = 1'b1;
                    od_next = '0;
                    od_next[7:0] = mem_rdata; od_next[8] = 1'b1;
                    ol_next = tot == num_reg;
                    if (tot == num_reg)
                    begin
                        if (consume_reg)
                        begin
                            held_next = held_reg - num_reg;
                            rp_next = wrap(rp_reg, num_reg, cap_reg);
                        end
                        od_next[24:18] = consume_reg ? held_reg - num_reg : held_reg;
                        state_next = brb_pkg::S_IDLE;
                    end
                    else
                    begin
                        od_next[24:18] = consume_reg ? held_reg - num_reg : held_reg;
                        idx_next = tot; roff = 7'(base_reg + tot);
                        rd_pend_next = 1'b1;
                    end
                end
                else if (rd_pend_reg)
                begin
                    rd_pend_next = 1'b0;
                end
                else
                begin
                    rd_pend_next = 1'b0;
                end
            end
            brb_pkg::S_SEARCH:
            begin
                if (!rd_pend_reg)
                begin
                    if (mem_rdata == pbyte)
                    begin
                        if (idx_reg + 7'd1 == 7'(plen_reg))
                        begin
                            num_next = base_reg + 7'(plen_reg);
                            state_next = brb_pkg::S_RESULT;
                        end
                        else
                        begin
                            idx_next = idx_reg + 7'd1;
                            roff = 7'(base_reg + idx_reg + 7'd1);
                            rd_pend_next = 1'b1;
                        end
                    end
                    else if (base_reg + 7'(plen_reg) >= held_reg)
                    begin
                        num_next = 7'd0;
                        state_next = brb_pkg::S_RESULT;
                    end
                    else
                    begin
                        base_next = base_reg + 7'd1; idx_next = 7'd0;
                        roff = base_reg + 7'd1;
                        rd_pend_next = 1'b1;
                    end
                end
            end
            brb_pkg::S_RESULT:
            begin
                if (num_reg == 0 || !til_reg)
                begin
                    if (out_free)
                    begin
                        ov_next = 1'b1; od_next = '0; ol_next = 1'b1;
                        od_next[10:9] = (num_reg == 0) ? brb_pkg::ST_NOTFOUND
                                                      : brb_pkg::ST_OK;
                        od_next[17:11] = num_reg;
                        od_next[24:18] = held_reg;
                        state_next = brb_pkg::S_IDLE;
                    end
                end
                else
                begin
                    base_next = 7'd0; idx_next = 7'd0; consume_next = 1'b1;
                    roff = 7'd0; rd_pend_next = 1'b1;
                    state_next = brb_pkg::S_EMIT;
                end
            end
            default: state_next = brb_pkg::S_IDLE;
        endcase

        if (cfg_we)
        begin
            unique case (cfg_index)
                brb_pkg::CFG_CAPACITY:
                begin
                    if (cfg_data[6:0] == 7'd0) cap_next = 7'd1;
                    else if (cfg_data[6:0] > CAP7) cap_next = CAP7;
                    else cap_next = cfg_data[6:0];
                    rp_next = '0; wp_next = '0; held_next = '0;
                    left_next = '0; rej_next = 1'b0;
                end
                brb_pkg::CFG_PATTERN: pat_next = cfg_data;
                brb_pkg::CFG_PAT_LEN:
                begin
                    if (cfg_data[3:0] == 4'd0) plen_next = PW'(1);
                    else if (cfg_data[3:0] > MAXP4) plen_next = PW'(MAX_PATTERN);
                    else plen_next = PW'(cfg_data[3:0]);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brb_pkg::S_IDLE;
            cap_reg <= CAP7; pat_reg <= 64'd2573; plen_reg <= PW'(2);
            rp_reg <= '0; wp_reg <= '0; held_reg <= '0; left_reg <= '0;
            rej_reg <= 1'b0; ov_reg <= 1'b0; rd_pend_reg <= 1'b0;
            base_reg <= '0; idx_reg <= '0; num_reg <= '0;
            consume_reg <= 1'b0; til_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cap_reg <= cap_next; pat_reg <= pat_next; plen_reg <= plen_next;
            rp_reg <= rp_next; wp_reg <= wp_next; held_reg <= held_next;
            left_reg <= left_next; rej_reg <= rej_next; ov_reg <= ov_next;
            rd_pend_reg <= rd_pend_next;
            base_reg <= base_next; idx_reg <= idx_next; num_reg <= num_next;
            consume_reg <= consume_next; til_reg <= til_next;
        end
    end

    always_ff @(posedge clk)
    begin
        od_reg <= od_next;
        ol_reg <= ol_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {7'd0, od_reg};
    assign m_tlast  = ol_reg;
endmodule
`default_nettype wire

FILE: verif/tb_byte_ring_buffer_with_pattern_search.sv
// Self-checking testbench for the byte ring buffer with pattern search.
`timescale 1ns / 1ps
module tb_byte_ring_buffer_with_pattern_search;

    localparam int CAP       = 64;
    localparam int MAXPAT    = 8;
    localparam int LIMIT     = 3000000;

    typedef struct {
        logic [2:0]        op;
        logic [7:0]        data;
        logic [6:0]        cnt;
        logic              first;
        logic              peek;
        logic signed [7:0] rs;
        logic signed [7:0] re;
    } ring_cmd_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [1:0] status;
        logic [6:0] value;
        logic [6:0] fill;
        logic       last;
    } ring_rsp_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    // shadow of the buffer state and registers
    logic [7:0]  shadow_mem [CAP];
    int          rd_ptr, wr_ptr, held, str_left;
    bit          str_reject;
    int          cap_used, pat_len;
    logic [63:0] pattern;

    ring_rsp_t   rsp_queue[$];
    int          errors, items_sent, rsp_seen, cycles;
    int          send_idle_pct, recv_idle_pct;

    byte_ring_buffer_with_pattern_search u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic ring_cmd_t mk(input logic [2:0] op, input int data, input int cnt,
                                     input bit first, input bit peek, input int rs, input int re);
        ring_cmd_t c;
        c.op = op; c.data = data[7:0]; c.cnt = cnt[6:0];
        c.first = first; c.peek = peek; c.rs = rs[7:0]; c.re = re[7:0];
        return c;
    endfunction

    function automatic logic [7:0] stored_at(input int base, input int off);
        return shadow_mem[(base + off) % cap_used];
    endfunction

    task automatic push_rsp(input int b, input bit v, input logic [1:0] st, input int val,
                            input bit last);
        ring_rsp_t r;
        r.out_byte = b[7:0]; r.byte_valid = v; r.status = st;
        r.value = val[6:0]; r.fill = held[6:0]; r.last = last;
        rsp_queue.push_back(r);
    endtask

    task automatic push_bytes(input int base, input int off, input int n);
        for (int k = 0; k < n; k++)
            push_rsp(stored_at(base, off + k), 1'b1, brb_pkg::ST_OK, 0, k + 1 == n);
    endtask

    function automatic int match_end();
        bit hit;
        if (held == 0 || pat_len > held)
            return 0;
        for (int i = 0; i + pat_len <= held; i++)
        begin
            hit = 1'b1;
            for (int j = 0; j < pat_len; j++)
                if (stored_at(rd_ptr, i + j) != pattern[j*8 +: 8])
                    hit = 1'b0;
            if (hit)
                return i + pat_len;
        end
        return 0;
    endfunction

    task automatic put_byte(input logic [7:0] b);
        shadow_mem[wr_ptr] = b;
        wr_ptr = (wr_ptr + 1) % cap_used;
        held++;
    endtask

    task automatic take(input int n);
        held -= n;
        rd_ptr = (rd_ptr + n) % cap_used;
    endtask

    task automatic empty_shadow();
        rd_ptr = 0; wr_ptr = 0; held = 0; str_left = 0; str_reject = 1'b0;
    endtask

    // work out every result one accepted word causes
    task automatic predict_ring(input ring_cmd_t c);
        int cnt, base, m, s, e;
        cnt = c.cnt;
        base = rd_ptr;
        case (c.op)
            brb_pkg::OP_WRITE:
            begin
                if (c.first)
                begin
                    str_reject = 1'b0;
                    str_left = 0;
                    if (cnt + held > cap_used)
                    begin
                        str_left = cnt > 0 ? cnt - 1 : 0;
                        str_reject = str_left > 0;
                        push_rsp(0, 0, brb_pkg::ST_SHORT, 0, 1);
                    end
                    else if (cnt == 0)
                        push_rsp(0, 0, brb_pkg::ST_OK, 0, 1);
                    else
                    begin
                        put_byte(c.data);
                        str_left = cnt - 1;
                        push_rsp(0, 0, brb_pkg::ST_OK, 1, 1);
                    end
                end
                else if (str_reject)
                begin
                    if (str_left > 0)
                        str_left--;
                    if (str_left == 0)
                        str_reject = 1'b0;
                    push_rsp(0, 0, brb_pkg::ST_SHORT, 0, 1);
                end
                else if (str_left > 0 && held < cap_used)
                begin
                    put_byte(c.data);
                    str_left--;
                    push_rsp(0, 0, brb_pkg::ST_OK, 1, 1);
                end
                else
                    push_rsp(0, 0, brb_pkg::ST_SHORT, 0, 1);
            end
            brb_pkg::OP_READ, brb_pkg::OP_DISCARD:
            begin
                if (cnt > held)
                    push_rsp(0, 0, brb_pkg::ST_SHORT, 0, 1);
                else
                begin
                    if (c.op == brb_pkg::OP_DISCARD || !c.peek)
                        take(cnt);
                    if (c.op == brb_pkg::OP_DISCARD || cnt == 0)
                        push_rsp(0, 0, brb_pkg::ST_OK, 0, 1);
                    else
                        push_bytes(base, 0, cnt);
                end
            end
            brb_pkg::OP_FIND, brb_pkg::OP_READ_TIL:
            begin
                m = match_end();
                if (m == 0)
                    push_rsp(0, 0, brb_pkg::ST_NOTFOUND, 0, 1);
                else if (c.op == brb_pkg::OP_FIND)
                    push_rsp(0, 0, brb_pkg::ST_OK, m, 1);
                else
                begin
                    take(m);
                    push_bytes(base, 0, m);
                end
            end
            brb_pkg::OP_SUB:
            begin
                s = c.rs;
                e = c.re;
                if (s < 0)
                    s = 1 + s + held;
                if (s < 1)
                    s = 1;
                if (e < 0)
                    e = 1 + e + held;
                if (e > held)
                    e = held;
                if (s > e)
                    push_rsp(0, 0, brb_pkg::ST_OK, 0, 1);
                else
                    push_bytes(rd_ptr, s - 1, e - s + 1);
            end
            default:
                push_rsp(0, 0, brb_pkg::ST_SHORT, 0, 1);
        endcase
    endtask

    // hold the word until taken; the valid stays high into the next word unless idling
    task automatic send_word(input ring_cmd_t c);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, c.re, c.rs, c.peek, c.first, c.cnt, c.data, c.op};
        do
            @(posedge clk);
        while (!s_tready);
        predict_ring(c);
        items_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (rsp_queue.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        int v;
        drain();
        @(negedge clk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        v = val[6:0];
        if (idx == brb_pkg::CFG_CAPACITY)
        begin
            v = val[6:0];
            cap_used = v < 1 ? 1 : (v > CAP ? CAP : v);
            empty_shadow();
        end
        else if (idx == brb_pkg::CFG_PATTERN)
            pattern = val;
        else
        begin
            v = val[3:0];
            pat_len = v < 1 ? 1 : (v > MAXPAT ? MAXPAT : v);
        end
    endtask

    function automatic int pick_data();
        if ($urandom_range(1))
            return pattern[$urandom_range(pat_len - 1)*8 +: 8];
        return $urandom_range(255);
    endfunction

    task automatic send_string(input int len, input int data0);
        send_word(mk(brb_pkg::OP_WRITE, data0, len, 1, 0, 0, 0));
        for (int k = 1; k < len; k++)
            send_word(mk(brb_pkg::OP_WRITE, pick_data(), 0, 0, 0, 0, 0));
    endtask

    task automatic test_directed();
        // "ab" CR LF "c": default pattern is CR LF
        send_word(mk(brb_pkg::OP_FIND, 0, 0, 0, 0, 0, 0));         // find on empty
        send_word(mk(brb_pkg::OP_WRITE, 8'h61, 5, 1, 0, 0, 0));
        send_word(mk(brb_pkg::OP_WRITE, 8'h62, 0, 0, 0, 0, 0));
        send_word(mk(brb_pkg::OP_READ, 0, 1, 0, 1, 0, 0));         // peek mid-string
        send_word(mk(brb_pkg::OP_WRITE, 8'h0D, 0, 0, 0, 0, 0));
        send_word(mk(brb_pkg::OP_WRITE, 8'h0A, 0, 0, 0, 0, 0));
        send_word(mk(brb_pkg::OP_WRITE, 8'h63, 0, 0, 0, 0, 0));
        send_word(mk(brb_pkg::OP_WRITE, 8'hFF, 0, 0, 0, 0, 0));    // stray byte
        send_word(mk(brb_pkg::OP_FIND, 0, 0, 0, 0, 0, 0));
        send_word(mk(brb_pkg::OP_SUB, 0, 0, 0, 0, -128, 127));
        send_word(mk(brb_pkg::OP_SUB, 0, 0, 0, 0, 127, -128));     // empty range
        send_word(mk(brb_pkg::OP_SUB, 0, 0, 0, 0, -2, -1));
        send_word(mk(brb_pkg::OP_READ, 0, 64, 0, 0, 0, 0));        // count too large
        send_word(mk(brb_pkg::OP_READ, 0, 0, 0, 0, 0, 0));
        send_word(mk(brb_pkg::OP_READ_TIL, 0, 0, 0, 1, 0, 0));
        send_word(mk(brb_pkg::OP_READ_TIL, 0, 0, 0, 0, 0, 0));     // not found
        send_word(mk(brb_pkg::OP_WRITE, 8'h00, 0, 1, 0, 0, 0));    // empty string
        send_word(mk(brb_pkg::OP_WRITE, 8'h00, 64, 1, 0, 0, 0));   // rejected string
        send_word(mk(brb_pkg::OP_WRITE, 8'h11, 0, 0, 0, 0, 0));
        send_word(mk(brb_pkg::OP_WRITE, 8'h22, 3, 1, 0, 0, 0));    // new string mid-string
        send_word(mk(brb_pkg::OP_WRITE, 8'h33, 0, 0, 0, 0, 0));
        send_word(mk(brb_pkg::OP_DISCARD, 0, 3, 0, 0, 0, 0));
        send_word(mk(brb_pkg::OP_DISCARD, 0, 64, 0, 0, 0, 0));
        send_word(mk(brb_pkg::OP_READ, 0, 1, 0, 0, 0, 0));
    endtask

    task automatic test_config_extremes();
        write_reg(brb_pkg::CFG_CAPACITY, 64'd0);                   // saturates to one
        write_reg(brb_pkg::CFG_PAT_LEN, 64'd0);
        write_reg(brb_pkg::CFG_PATTERN, 64'hFFFF_FFFF_FFFF_FF00);
        send_string(1, 8'h00);
        send_word(mk(brb_pkg::OP_WRITE, 8'h5A, 1, 1, 0, 0, 0));    // full
        send_word(mk(brb_pkg::OP_READ_TIL, 0, 0, 0, 0, 0, 0));
        write_reg(brb_pkg::CFG_CAPACITY, 64'd127);
        write_reg(brb_pkg::CFG_PAT_LEN, 64'd15);
        send_string(64, 8'hFF);
        send_word(mk(brb_pkg::OP_FIND, 0, 0, 0, 0, 0, 0));
        send_word(mk(brb_pkg::OP_READ, 0, 64, 0, 0, 0, 0));
        write_reg(brb_pkg::CFG_PATTERN, 64'h0706_0504_0302_0100);
        for (int k = 0; k < 8; k++)
            send_word(mk(brb_pkg::OP_WRITE, k, k == 0 ? 8 : 0, k == 0, 0, 0, 0));
        send_word(mk(brb_pkg::OP_FIND, 0, 0, 0, 0, 0, 0));
        send_word(mk(brb_pkg::OP_READ_TIL, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_random_traffic(input int n);
        int stop, r, len, op;
        stop = items_sent + n;
        while (items_sent < stop)
        begin
            r = $urandom_range(99);
            if (r < 45)
            begin
                len = $urandom_range(0, cap_used - held + ($urandom_range(3) == 0 ? 3 : 0));
                if (len > 64)
                    len = 64;
                send_string(len, pick_data());
            end
            else if (r < 50)
                send_word(mk(brb_pkg::OP_WRITE, $urandom_range(255), $urandom_range(64), 0,
                             $urandom_range(1), 0, 0));
            else
            begin
                op = $urandom_range(brb_pkg::OP_READ, brb_pkg::OP_SUB);
                send_word(mk(3'(op), $urandom_range(255),
                             $urandom_range(3) == 0 ? $urandom_range(64)
                                                    : $urandom_range(0, held + 1),
                             $urandom_range(1), $urandom_range(1),
                             $urandom_range(255), $urandom_range(255)));
            end
        end
    endtask

    // compare each taken result with the oldest prediction
    always @(posedge clk)
    begin
        ring_rsp_t want;
        ring_rsp_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.out_byte = m_tdata[7:0];
            got.byte_valid = m_tdata[8];
            got.status = m_tdata[10:9];
            got.value = m_tdata[17:11];
            got.fill = m_tdata[24:18];
            got.last = m_tlast;
            rsp_seen++;
            if (rsp_queue.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %p", $time, got);
            end
            else
            begin
                want = rsp_queue.pop_front();
                if (want != got)
                begin
                    errors++;
                    $display("%0t: mismatch expected %p actual %p", $time, want, got);
                end
            end
        end
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout with %0d results pending", rsp_queue.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0; s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        errors = 0; items_sent = 0; rsp_seen = 0; cycles = 0;
        send_idle_pct = 27; recv_idle_pct = 56;
        cap_used = CAP; pattern = 64'd2573; pat_len = 2;
        empty_shadow();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_config_extremes();

        write_reg(brb_pkg::CFG_CAPACITY, 64'd64);
        write_reg(brb_pkg::CFG_PATTERN, {$urandom, $urandom});
        write_reg(brb_pkg::CFG_PAT_LEN, 64'd2);
        test_random_traffic(80);

        send_idle_pct = 56; recv_idle_pct = 27;
        write_reg(brb_pkg::CFG_CAPACITY, 64'd5);
        write_reg(brb_pkg::CFG_PAT_LEN, 64'd1);
        test_random_traffic(75);

        send_idle_pct = 0; recv_idle_pct = 0;
        write_reg(brb_pkg::CFG_CAPACITY, $urandom_range(2, 64));
        write_reg(brb_pkg::CFG_PATTERN, {$urandom, $urandom});
        write_reg(brb_pkg::CFG_PAT_LEN, 64'd3);
        test_random_traffic(75);

        drain();
        $display("Covered %0d words and %0d results over directed cases,", items_sent, rsp_seen);
        $display("register extremes and three random traffic phases; %0d errors.", errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
hdl/brb_pkg.sv
hdl/brb_store.sv
hdl/byte_ring_buffer_with_pattern_search.sv
verif/tb_byte_ring_buffer_with_pattern_search.sv
